>>> src/ccfd_pkg.sv
`default_nettype none

package ccfd_pkg;

    localparam int BUF_DEPTH = 4096;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int MIN_FRAME = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  BYTE_MAX = 8'hFF;

    localparam logic REQ_FEED = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_FRAMING = 2'd2,
        ST_CRC     = 2'd3
    } frame_status_t;

    typedef struct packed {
        frame_status_t status;
        logic [7:0]    frame_type;
        logic [7:0]    frame_seq;
        logic [11:0]   payload_len;
        logic          rd_valid;
        logic [31:0]   framing_error_count;
        logic [31:0]   crc_error_count;
    } ccfd_meta_t;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } ccfd_ram_req_t;

    typedef struct packed {
        ccfd_meta_t meta;
        logic [7:0] read_data;
    } ccfd_result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
        logic [15:0] c;
        c = crc ^ {v, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/ccfd_frame_ram.sv
`default_nettype none

module ccfd_frame_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/ccfd_decoder.sv
`default_nettype none

module ccfd_decoder
    import ccfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_req,
    input  wire logic [7:0]    in_byte,
    input  wire logic [11:0]   in_index,
    output ccfd_ram_req_t      ram_req,
    output logic               out_valid,
    output ccfd_meta_t         out_meta,
    input  wire logic          out_ready
);

    logic             crc_big_endian_reg;
    logic [CNT_W-1:0] stored_count_reg, stored_count_next;
    logic [7:0]       block_remaining_reg, block_remaining_next;
    logic             block_ends_zero_reg, block_ends_zero_next;
    logic             overflowed_reg, overflowed_next;
    logic [15:0]      running_crc_reg, running_crc_next;
    logic [15:0]      last_two_reg, last_two_next;
    logic [31:0]      framing_errors_reg, framing_errors_next;
    logic [31:0]      crc_errors_reg, crc_errors_next;
    logic [7:0]       hdr_type_reg, hdr_type_next;
    logic [7:0]       hdr_seq_reg, hdr_seq_next;
    logic             a_valid_reg, a_valid_next;
    ccfd_meta_t       a_meta_reg, a_meta_next;

    logic             in_fire;
    logic             is_delim;
    logic             store_req;
    logic [7:0]       store_val;
    logic [15:0]      rx_crc;
    logic [CNT_W-1:0] plen_full;
    ccfd_meta_t       item_meta;

    assign in_ready  = !a_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign is_delim  = (in_req == REQ_FEED) && (in_byte == 8'h00);
    assign out_valid = a_valid_reg;
    assign out_meta  = a_meta_reg;
    assign rx_crc    = crc_big_endian_reg ? last_two_reg
                                          : {last_two_reg[7:0], last_two_reg[15:8]};
    assign plen_full = stored_count_reg - CNT_W'(MIN_FRAME);

    always_comb
    begin
        stored_count_next    = stored_count_reg;
        block_remaining_next = block_remaining_reg;
        block_ends_zero_next = block_ends_zero_reg;
        overflowed_next      = overflowed_reg;
        running_crc_next     = running_crc_reg;
        last_two_next        = last_two_reg;
        framing_errors_next  = framing_errors_reg;
        crc_errors_next      = crc_errors_reg;
        hdr_type_next        = hdr_type_reg;
        hdr_seq_next         = hdr_seq_reg;
        item_meta            = '0;
        ram_req              = '0;
        store_req            = 1'b0;
        store_val            = in_byte;

        if (in_fire)
        begin
            if (in_req == REQ_READ)
            begin
                ram_req.re        = 1'b1;
                ram_req.raddr     = BUF_AW'(in_index);
                item_meta.rd_valid = (32'(in_index) < 32'(BUF_DEPTH));
            end
            else if (is_delim)
            begin
                if (stored_count_reg != '0 || block_remaining_reg != '0 || overflowed_reg)
                begin
                    if (overflowed_reg || block_remaining_reg != '0
                        || stored_count_reg < CNT_W'(MIN_FRAME))
                    begin
                        framing_errors_next = framing_errors_reg + 32'd1;
                        item_meta.status    = ST_FRAMING;
                    end
                    else if (rx_crc != running_crc_reg)
                    begin
                        crc_errors_next  = crc_errors_reg + 32'd1;
                        item_meta.status = ST_CRC;
                    end
                    else
                    begin
                        item_meta.status      = ST_GOOD;
                        item_meta.frame_type  = hdr_type_reg;
                        item_meta.frame_seq   = hdr_seq_reg;
                        item_meta.payload_len = 12'(plen_full);
                    end
                end
                stored_count_next    = '0;
                block_remaining_next = '0;
                block_ends_zero_next = 1'b0;
                overflowed_next      = 1'b0;
                running_crc_next     = CRC_INIT;
                last_two_next        = '0;
            end
            else if (!overflowed_reg)
            begin
                if (block_remaining_reg == '0)
                begin
                    store_req            = block_ends_zero_reg;
                    store_val            = 8'h00;
                    block_remaining_next = in_byte - 8'd1;
                    block_ends_zero_next = (in_byte != BYTE_MAX);
                end
                else
                begin
                    store_req            = 1'b1;
                    block_remaining_next = block_remaining_reg - 8'd1;
                end
            end
        end

        if (store_req)
        begin
            if (stored_count_reg < CNT_W'(BUF_DEPTH))
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = BUF_AW'(stored_count_reg);
                ram_req.wdata = store_val;
                if (stored_count_reg >= CNT_W'(2))
                begin
                    running_crc_next = crc_byte(running_crc_reg, last_two_reg[15:8]);
                end
                if (stored_count_reg == CNT_W'(0))
                begin
                    hdr_type_next = store_val;
                end
                if (stored_count_reg == CNT_W'(1))
                begin
                    hdr_seq_next = store_val;
                end
                last_two_next     = {last_two_reg[7:0], store_val};
                stored_count_next = stored_count_reg + CNT_W'(1);
            end
            else
            begin
                overflowed_next = 1'b1;
            end
        end

        item_meta.framing_error_count = framing_errors_next;
        item_meta.crc_error_count     = crc_errors_next;

        a_valid_next = in_fire || (a_valid_reg && !out_ready);
        a_meta_next  = in_fire ? item_meta : a_meta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_big_endian_reg  <= 1'b0;
            stored_count_reg    <= '0;
            block_remaining_reg <= '0;
            block_ends_zero_reg <= 1'b0;
            overflowed_reg      <= 1'b0;
            running_crc_reg     <= CRC_INIT;
            last_two_reg        <= '0;
            framing_errors_reg  <= '0;
            crc_errors_reg      <= '0;
            a_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                crc_big_endian_reg <= cfg_wdata;
            end
            stored_count_reg    <= stored_count_next;
            block_remaining_reg <= block_remaining_next;
            block_ends_zero_reg <= block_ends_zero_next;
            overflowed_reg      <= overflowed_next;
            running_crc_reg     <= running_crc_next;
            last_two_reg        <= last_two_next;
            framing_errors_reg  <= framing_errors_next;
            crc_errors_reg      <= crc_errors_next;
            a_valid_reg         <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_type_reg <= hdr_type_next;
        hdr_seq_reg  <= hdr_seq_next;
        a_meta_reg   <= a_meta_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= CNT_W'(BUF_DEPTH))
        else $error("stored count past buffer depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> stored_count_reg == CNT_W'(BUF_DEPTH))
        else $error("overflow flagged with buffer not full");

    a_delim_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_delim) |=>
            (stored_count_reg == '0 && !overflowed_reg && running_crc_reg == CRC_INIT))
        else $error("delimiter did not restart frame");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !out_ready) |=> (a_valid_reg && $stable(a_meta_reg)))
        else $error("stalled result lost or changed");
`endif

endmodule

`default_nettype wire

>>> src/ccfd_out_queue.sv
`default_nettype none

module ccfd_out_queue
    import ccfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire ccfd_result_t  push_item,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output ccfd_result_t       pop_item
);

    ccfd_result_t entry_reg [2];
    logic [1:0]   count_reg, count_next;
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic         push_fire;
    logic         pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_fire;
        rd_ptr_next = rd_ptr_reg ^ pop_fire;
        count_next  = count_reg + {1'b0, push_fire} - {1'b0, pop_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("output queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd1) == (wr_ptr_reg == rd_ptr_reg))
        else $error("output queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> src/cobs_crc_frame_decoder.sv
// Each result passes the decoder's output register and then the output queue to m_tvalid.
// Throughput: one word per cycle while the output queue has room; set by the single-write,
// single-read frame buffer RAM and the one-byte-per-cycle CRC step.
// A two-entry output queue keeps input flowing while a result waits on m_tready.
// Reset clears decode state, error counts and crc_big_endian; buffer contents stay undefined.
`default_nettype none

module cobs_crc_frame_decoder
    import ccfd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,     // crc_big_endian
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,       // line_byte, read_index
    input  wire logic [0:0]   s_tuser,       // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [103:0] m_tdata,       // frame_type, frame_seq, payload_len, read_data,
                                             // framing_error_count, crc_error_count
    output logic      [1:0]   m_tuser        // frame_status
);

    ccfd_ram_req_t ram_req;
    logic [7:0]    ram_rdata;
    logic          a_valid;
    logic          a_ready;
    ccfd_meta_t    a_meta;
    ccfd_result_t  push_item;
    ccfd_result_t  pop_item;

    ccfd_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser[0]),
        .in_byte   (s_tdata[7:0]),
        .in_index  (s_tdata[19:8]),
        .ram_req   (ram_req),
        .out_valid (a_valid),
        .out_meta  (a_meta),
        .out_ready (a_ready)
    );

    ccfd_frame_ram #(
        .ADDR_W (BUF_AW),
        .DATA_W (8)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign push_item.meta      = a_meta;
    assign push_item.read_data = a_meta.rd_valid ? ram_rdata : 8'h00;

    ccfd_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (a_valid),
        .push_ready (a_ready),
        .push_item  (push_item),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_item   (pop_item)
    );

    assign m_tuser = pop_item.meta.status;
    assign m_tdata = {4'h0,
                      pop_item.meta.crc_error_count,
                      pop_item.meta.framing_error_count,
                      pop_item.read_data,
                      pop_item.meta.payload_len,
                      pop_item.meta.frame_seq,
                      pop_item.meta.frame_type};

endmodule

`default_nettype wire
